/* hw/rtl/dlmh_pkg.sv */
// Package with the transfer types, hash constants and multiplier request type.
package dlmh_pkg;

    localparam logic [63:0] SEED_HIGH = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SEED_LOW  = 64'hC6BC_2796_92B5_C323;
    localparam logic [63:0] MULT_HIGH = 64'h9FB2_1C65_1E98_DF25;
    localparam logic [63:0] MULT_LOW  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] FMIX_HIGH = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [63:0] FMIX_LOW  = 64'hC4CE_B9FE_1A85_EC53;

    localparam int unsigned SHIFT_HIGH = 27;
    localparam int unsigned SHIFT_LOW  = 31;
    localparam int unsigned SHIFT_FMIX = 33;

    localparam logic [3:0] FULL_COUNT = 4'd8;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last;
        logic [31:0] total_length;
    } dlmh_item_t;

    typedef struct packed {
        logic [63:0] hash_high;
        logic [63:0] hash_low;
    } dlmh_hash_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } dlmh_mul_req_t;

endpackage

/* hw/rtl/dlmh_mul.sv */
// Iterative 64-bit modular multiplier built on one shared 32x32 multiplier.
module dlmh_mul
    import dlmh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  dlmh_mul_req_t req,
    output logic          done,
    output logic [63:0]   product
);

    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_LL,
        STEP_HL,
        STEP_LH,
        STEP_DONE
    } step_t;

    step_t       step_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] mult;
    logic [31:0] acc_upper;

    always_comb
    begin
        unique case (step_reg)
            STEP_LL:
            begin
                op_a = req.a[31:0];
                op_b = req.b[31:0];
            end
            STEP_HL:
            begin
                op_a = req.a[63:32];
                op_b = req.b[31:0];
            end
            default:
            begin
                op_a = req.a[31:0];
                op_b = req.b[63:32];
            end
        endcase
        mult = {32'd0, op_a} * {32'd0, op_b};
        acc_upper = acc_reg[63:32] + prod_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
            prod_reg <= 64'd0;
            acc_reg  <= 64'd0;
        end
        else
        begin
            unique case (step_reg)
                STEP_IDLE:
                begin
                    if (req.start)
                    begin
                        step_reg <= STEP_LL;
                    end
                end
                STEP_LL:
                begin
                    prod_reg <= mult;
                    step_reg <= STEP_HL;
                end
                STEP_HL:
                begin
                    prod_reg <= mult;
                    acc_reg  <= prod_reg;
                    step_reg <= STEP_LH;
                end
                STEP_LH:
                begin
                    prod_reg        <= mult;
                    acc_reg[63:32] <= acc_upper;
                    step_reg        <= STEP_DONE;
                end
                STEP_DONE:
                begin
                    step_reg <= STEP_IDLE;
                end
                default:
                begin
                    step_reg <= STEP_IDLE;
                end
            endcase
        end
    end

    assign done    = (step_reg == STEP_DONE);
    assign product = {acc_upper, acc_reg[31:0]};

endmodule

/* hw/rtl/dual_lane_multiply_hash_unit.sv */
// Top level of the two-lane multiply and xorshift message hash.
//
// Channel | Signals                        | Direction | Transfer when
// item    | item_valid, item_stall, item   | in        | item_valid && !item_stall
// hash    | hash_valid, hash_stall, hash   | out       | hash_valid && !hash_stall
//
// A word with one or more bytes passes through both lane multiplies; a word with no bytes skips them.
// A last word adds finalization, then S_EMIT loads the output register once it is free.
// The pace is set by the shared 32x32 multiplier, three passes per 64-bit product.
// Reset clears the sequencer and the output valid and re-arms seeding.
// A stalled result holds in the output register while the next message streams in.
module dual_lane_multiply_hash_unit
    import dlmh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  dlmh_item_t item,
    output logic       hash_valid,
    input  logic       hash_stall,
    output dlmh_hash_t hash
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_HI,
        S_MUL_LO,
        S_FIN_PRE,
        S_FIN_HI,
        S_FIN_LO,
        S_EMIT
    } state_t;

    state_t        state_reg, state_next;
    logic [63:0]   lane_high_reg, lane_high_next;
    logic [63:0]   lane_low_reg, lane_low_next;
    logic          awaiting_reg, awaiting_next;
    logic          full_reg, full_next;
    logic          last_reg, last_next;
    logic          start_reg, start_next;
    logic          hash_valid_reg, hash_valid_next;
    dlmh_hash_t    hash_reg, hash_next;

    logic          accept;
    logic [3:0]    count_sat;
    logic [63:0]   masked_word;
    logic [63:0]   seed_high;
    logic [63:0]   seed_low;
    logic          out_free;
    dlmh_mul_req_t mul_req;
    logic          mul_done;
    logic [63:0]   mul_product;

    dlmh_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_product)
    );

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !hash_valid_reg || !hash_stall;

    always_comb
    begin
        count_sat = (item.byte_count > FULL_COUNT) ? FULL_COUNT : item.byte_count;
        for (int i = 0; i < 8; i++)
        begin
            masked_word[i*8 +: 8] = (4'(i) < count_sat) ? item.data_word[i*8 +: 8] : 8'd0;
        end
        seed_high = awaiting_reg ? (SEED_HIGH ^ {32'd0, item.total_length}) : lane_high_reg;
        seed_low  = awaiting_reg ? (SEED_LOW ^ {32'd0, item.total_length}) : lane_low_reg;
    end

    always_comb
    begin
        mul_req.start = start_reg;
        mul_req.a     = lane_high_reg;
        mul_req.b     = MULT_HIGH;
        unique case (state_reg)
            S_MUL_LO:
            begin
                mul_req.a = lane_low_reg;
                mul_req.b = MULT_LOW;
            end
            S_FIN_HI:
            begin
                mul_req.b = FMIX_HIGH;
            end
            S_FIN_LO:
            begin
                mul_req.a = lane_low_reg;
                mul_req.b = FMIX_LOW;
            end
            default:
            begin
                mul_req.b = MULT_HIGH;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        lane_high_next  = lane_high_reg;
        lane_low_next   = lane_low_reg;
        awaiting_next   = awaiting_reg;
        full_next       = full_reg;
        last_next       = last_reg;
        start_next      = 1'b0;
        hash_valid_next = hash_valid_reg && hash_stall;
        hash_next       = hash_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    awaiting_next  = 1'b0;
                    full_next      = (count_sat == FULL_COUNT);
                    last_next      = item.last;
                    lane_high_next = seed_high;
                    lane_low_next  = seed_low;
                    if (count_sat != 4'd0)
                    begin
                        lane_high_next = seed_high ^ masked_word;
                        lane_low_next  = seed_low + masked_word;
                        start_next     = 1'b1;
                        state_next     = S_MUL_HI;
                    end
                    else if (item.last)
                    begin
                        state_next = S_FIN_PRE;
                    end
                end
            end
            S_MUL_HI:
            begin
                if (mul_done)
                begin
                    lane_high_next = mul_product ^
                        (full_reg ? (lane_high_reg >> SHIFT_HIGH) : 64'd0);
                    start_next = 1'b1;
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                if (mul_done)
                begin
                    lane_low_next = mul_product ^
                        (full_reg ? (lane_low_reg >> SHIFT_LOW) : 64'd0);
                    state_next = last_reg ? S_FIN_PRE : S_IDLE;
                end
            end
            S_FIN_PRE:
            begin
                lane_high_next = lane_high_reg ^ (lane_high_reg >> SHIFT_FMIX);
                lane_low_next  = lane_low_reg ^ (lane_low_reg >> SHIFT_FMIX);
                start_next     = 1'b1;
                state_next     = S_FIN_HI;
            end
            S_FIN_HI:
            begin
                if (mul_done)
                begin
                    lane_high_next = mul_product ^ (mul_product >> SHIFT_FMIX);
                    start_next     = 1'b1;
                    state_next     = S_FIN_LO;
                end
            end
            S_FIN_LO:
            begin
                if (mul_done)
                begin
                    lane_low_next = mul_product ^ (mul_product >> SHIFT_FMIX);
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    hash_valid_next    = 1'b1;
                    hash_next.hash_high = lane_high_reg;
                    hash_next.hash_low  = lane_low_reg;
                    awaiting_next      = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            lane_high_reg  <= 64'd0;
            lane_low_reg   <= 64'd0;
            awaiting_reg   <= 1'b1;
            full_reg       <= 1'b0;
            last_reg       <= 1'b0;
            start_reg      <= 1'b0;
            hash_valid_reg <= 1'b0;
            hash_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            lane_high_reg  <= lane_high_next;
            lane_low_reg   <= lane_low_next;
            awaiting_reg   <= awaiting_next;
            full_reg       <= full_next;
            last_reg       <= last_next;
            start_reg      <= start_next;
            hash_valid_reg <= hash_valid_next;
            hash_reg       <= hash_next;
        end
    end

    assign hash_valid = hash_valid_reg;
    assign hash       = hash_reg;

endmodule

/* hw/rtl/dlmh_checker.sv */
// Port-level checker for the hash unit and the bind that attaches it.
module dlmh_checker
    import dlmh_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input dlmh_item_t item,
    input logic       hash_valid,
    input logic       hash_stall,
    input dlmh_hash_t hash
);

    assert property (@(posedge clk) disable iff (!rst_n)
        hash_valid && hash_stall |=> hash_valid && $stable(hash))
    else $error("Stalled hash result changed or dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.last |=> item_stall)
    else $error("Unit took a new item right after a last word.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hash_valid) |-> $past(item_stall))
    else $error("Hash result appeared without a busy period.");

    assert property (@(posedge clk)
        $rose(rst_n) |-> !hash_valid)
    else $error("Hash valid high when leaving reset.");

endmodule

bind dual_lane_multiply_hash_unit dlmh_checker u_dlmh_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .hash_valid (hash_valid),
    .hash_stall (hash_stall),
    .hash       (hash)
);
